// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file of the frame checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FPC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/fpc_pkg.sv -----
// Types and constants of the framed packet checker.
`timescale 1ns / 1ps

package fpc_pkg;

  typedef enum logic [2:0] {
    PH_START    = 3'd0,
    PH_CONTROL  = 3'd1,
    PH_LENGTH   = 3'd2,
    PH_DATA     = 3'd3,
    PH_CHECKSUM = 3'd4,
    PH_STOP     = 3'd5,
    PH_ERROR    = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_START    = 3'd1,
    ERR_CONTROL  = 3'd2,
    ERR_LENGTH   = 3'd3,
    ERR_CHECKSUM = 3'd4,
    ERR_STOP     = 3'd5
  } err_t;

  typedef enum logic [1:0] {
    REG_START_CODE   = 2'd0,
    REG_STOP_CODE    = 2'd1,
    REG_COMMAND_CODE = 2'd2
  } reg_idx_t;

  localparam logic [7:0] START_CODE_RST   = 8'hAA;
  localparam logic [7:0] STOP_CODE_RST    = 8'h55;
  localparam logic [7:0] COMMAND_CODE_RST = 8'h00;
  localparam logic [7:0] LEN_MIN          = 8'd3;
  localparam int         LEN_MARGIN       = 5;

  typedef struct packed {
    logic [7:0] start_code;
    logic [7:0] stop_code;
    logic [7:0] command_code;
  } cfg_t;

  typedef struct packed {
    logic       byte_stored;
    logic [7:0] stored_byte;
    logic [7:0] stored_index;
    logic       frame_done;
    err_t       error_code;
    logic       resynced;
  } result_t;

endpackage

// ----- rtl/core/fpc_cfg.sv -----
// Configuration register file of the framed packet checker.
`timescale 1ns / 1ps

module fpc_cfg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [7:0]      cfg_wdata,
  output fpc_pkg::cfg_t   cfg
);

  fpc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_code   <= fpc_pkg::START_CODE_RST;
      cfg_r.stop_code    <= fpc_pkg::STOP_CODE_RST;
      cfg_r.command_code <= fpc_pkg::COMMAND_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fpc_pkg::REG_START_CODE:   cfg_r.start_code   <= cfg_wdata;
        fpc_pkg::REG_STOP_CODE:    cfg_r.stop_code    <= cfg_wdata;
        fpc_pkg::REG_COMMAND_CODE: cfg_r.command_code <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/core/fpc_parse.sv -----
// Input register and per-byte frame parser of the framed packet checker.
`timescale 1ns / 1ps

module fpc_parse #(
  parameter int FRAME_SIZE = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fpc_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  output logic              res_valid,
  input  logic              res_ready,
  output fpc_pkg::result_t  res
);

  localparam logic [7:0] LEN_MAX = 8'(FRAME_SIZE - fpc_pkg::LEN_MARGIN);

  logic                 hold_valid_r;
  logic [7:0]           hold_byte_r;
  logic                 step;

  fpc_pkg::phase_t      phase_r, phase_nxt;
  logic [7:0]           left_r, left_nxt;
  logic [7:0]           sum_r, sum_nxt;
  logic [7:0]           pos_r, pos_nxt;
  logic [7:0]           prev_r, prev_nxt;

  // The held byte is consumed whenever the result side can take its result.
  assign step      = hold_valid_r && res_ready;
  assign res_valid = hold_valid_r;
  assign in_ready  = !hold_valid_r || res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_ready) begin
      hold_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_byte_r <= in_byte;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    sum_nxt   = sum_r;
    pos_nxt   = pos_r;
    prev_nxt  = prev_r;
    res       = '0;
    case (phase_r)
      fpc_pkg::PH_START: begin
        if (hold_byte_r == cfg.start_code) begin
          res.byte_stored = 1'b1;
          res.stored_byte = hold_byte_r;
          pos_nxt         = 8'd1;
          phase_nxt       = fpc_pkg::PH_CONTROL;
        end else begin
          res.error_code = fpc_pkg::ERR_START;
          phase_nxt      = fpc_pkg::PH_ERROR;
        end
      end
      fpc_pkg::PH_CONTROL: begin
        if (hold_byte_r == cfg.command_code) begin
          res.byte_stored  = 1'b1;
          res.stored_byte  = hold_byte_r;
          res.stored_index = pos_r;
          pos_nxt          = pos_r + 8'd1;
          sum_nxt          = hold_byte_r;
          phase_nxt        = fpc_pkg::PH_LENGTH;
        end else begin
          res.error_code = fpc_pkg::ERR_CONTROL;
          phase_nxt      = fpc_pkg::PH_ERROR;
        end
      end
      fpc_pkg::PH_LENGTH: begin
        if (hold_byte_r >= fpc_pkg::LEN_MIN && hold_byte_r <= LEN_MAX) begin
          res.byte_stored  = 1'b1;
          res.stored_byte  = hold_byte_r;
          res.stored_index = pos_r;
          pos_nxt          = pos_r + 8'd1;
          left_nxt         = hold_byte_r;
          sum_nxt          = sum_r + hold_byte_r;
          phase_nxt        = fpc_pkg::PH_DATA;
        end else begin
          res.error_code = fpc_pkg::ERR_LENGTH;
          phase_nxt      = fpc_pkg::PH_ERROR;
        end
      end
      fpc_pkg::PH_DATA: begin
        // With no data byte left the byte is dropped and the checksum follows.
        if (left_r != 8'd0) begin
          res.byte_stored  = 1'b1;
          res.stored_byte  = hold_byte_r;
          res.stored_index = pos_r;
          pos_nxt          = pos_r + 8'd1;
          left_nxt         = left_r - 8'd1;
          sum_nxt          = sum_r + hold_byte_r;
          if (left_r == 8'd1) begin
            phase_nxt = fpc_pkg::PH_CHECKSUM;
          end
        end else begin
          phase_nxt = fpc_pkg::PH_CHECKSUM;
        end
      end
      fpc_pkg::PH_CHECKSUM: begin
        if (hold_byte_r == sum_r) begin
          res.byte_stored  = 1'b1;
          res.stored_byte  = hold_byte_r;
          res.stored_index = pos_r;
          pos_nxt          = pos_r + 8'd1;
          phase_nxt        = fpc_pkg::PH_STOP;
        end else begin
          res.error_code = fpc_pkg::ERR_CHECKSUM;
          phase_nxt      = fpc_pkg::PH_ERROR;
        end
      end
      fpc_pkg::PH_STOP: begin
        if (hold_byte_r == cfg.stop_code) begin
          res.byte_stored  = 1'b1;
          res.stored_byte  = hold_byte_r;
          res.stored_index = pos_r;
          res.frame_done   = 1'b1;
          pos_nxt          = pos_r + 8'd1;
          phase_nxt        = fpc_pkg::PH_START;
        end else begin
          res.error_code = fpc_pkg::ERR_STOP;
          phase_nxt      = fpc_pkg::PH_ERROR;
        end
      end
      fpc_pkg::PH_ERROR: begin
        // The previous byte is kept across a resync on purpose.
        if (prev_r == cfg.stop_code && hold_byte_r == cfg.start_code) begin
          res.byte_stored = 1'b1;
          res.stored_byte = hold_byte_r;
          res.resynced    = 1'b1;
          pos_nxt         = 8'd1;
          phase_nxt       = fpc_pkg::PH_CONTROL;
        end else begin
          prev_nxt = hold_byte_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= fpc_pkg::PH_START;
      left_r  <= 8'd0;
      sum_r   <= 8'd0;
      pos_r   <= 8'd0;
      prev_r  <= 8'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      sum_r   <= sum_nxt;
      pos_r   <= pos_nxt;
      prev_r  <= prev_nxt;
    end
  end

endmodule

// ----- rtl/core/fpc_outreg.sv -----
// Result register of the framed packet checker, packed onto the output stream.
`timescale 1ns / 1ps

module fpc_outreg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  output logic              res_ready,
  input  fpc_pkg::result_t  res,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,
  output logic              out_tlast
);

  logic              out_valid_r;
  fpc_pkg::result_t  out_res_r;

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_res_r.frame_done;
  assign out_tdata  = {3'b000, out_res_r.resynced, out_res_r.error_code,
                       out_res_r.stored_index, out_res_r.stored_byte,
                       out_res_r.byte_stored};

endmodule

// ----- rtl/core/framed_packet_checker.sv -----
// Top level of the framed packet checker.
`timescale 1ns / 1ps

// The checker takes one received byte per request and returns exactly one
// result per byte. Frames are laid out as start code, control code, length,
// length data bytes, checksum and stop code; the checksum is the 8-bit
// wrapping sum of the control, length and data bytes, and the length must
// lie from 3 to FRAME_SIZE-5. Each byte taken into the frame is reported with
// its position (start code at 0), the stop code of a good frame raises
// out_tlast, and a format violation reports an error code and drops the
// parser into an error state. That state leaves when a stop-code byte is
// followed by a start-code byte, which is reported as a resync and stored at
// position 0. The stop-code byte is the one most recently seen in the error
// state, and it survives a resync. Throughput is one byte per clock while the
// output stream does not stall: each byte goes from the input register
// through the parser's combinational next-state logic into the result
// register, and either stream may stall without losing data.
// Configuration registers (start, stop and command code) should be written
// only while no byte is in flight.

module framed_packet_checker #(
  parameter int FRAME_SIZE = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  // Received byte stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [0] byte_stored, [8:1] stored_byte,
                                  // [16:9] stored_index, [19:17] error_code,
                                  // [20] resynced, [23:21] zero
  output logic        out_tlast   // frame_done
);

  fpc_pkg::cfg_t     cfg;
  fpc_pkg::result_t  res;
  logic              res_valid;
  logic              res_ready;

  fpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  fpc_parse #(
    .FRAME_SIZE (FRAME_SIZE)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  fpc_outreg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- rtl/core/fpc_checker.sv -----
// Port-level assertions of the framed packet checker and their bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fpc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);

  // Result fields unpacked from the output stream.
  logic       stored;
  logic [7:0] idx;
  logic [2:0] err;
  logic       resync;

  assign stored = out_tdata[0];
  assign idx    = out_tdata[16:9];
  assign err    = out_tdata[19:17];
  assign resync = out_tdata[20];

  // A completed frame always ends on a stored, error-free stop byte.
  `FPC_ASSERT_IMP(a_done_stored, out_tvalid && out_tlast, stored && err == fpc_pkg::ERR_NONE)

  // An error result never stores the byte nor reports a resync.
  `FPC_ASSERT_IMP(a_err_not_stored, out_tvalid && err != fpc_pkg::ERR_NONE, !stored && !resync)

  // A resync stores the start byte at position 0 and does not end a frame.
  `FPC_ASSERT_IMP(a_resync_pos0, out_tvalid && resync, stored && idx == 8'd0 && !out_tlast)

  // A stalled result stays put.
  `FPC_ASSERT_NXT(a_stall_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))

endmodule

bind framed_packet_checker fpc_checker u_fpc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
